[src/bmpd_pkg.sv]
// Shared types and constants for the BMP 24-bit stream decoder.
// Used by bmpd_front, bmpd_queue, bmpd_back and bmp_rgb24_stream_decoder.
`default_nettype none

package bmpd_pkg;

  // Largest accepted width or height.
  localparam int unsigned MAX_DIM = 4096;
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  // Field widths of a result word.
  localparam int COORD_W  = 12;
  localparam int STATUS_W = 3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PIXEL      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIG    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PLANES = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_DEPTH  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_COMP   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE   = 3'd5;

  // Kinds of token passed from the front to the back.
  localparam logic [1:0] TK_BLUE  = 2'd0;
  localparam logic [1:0] TK_GREEN = 2'd1;
  localparam logic [1:0] TK_RED   = 2'd2;
  localparam logic [1:0] TK_ERROR = 2'd3;

  // Token queue depth.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]          kind;
    logic [STATUS_W-1:0] status;
    logic [7:0]          data;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  column;
    logic                last;
  } token_t;

endpackage

`default_nettype wire

[src/bmpd_front.sv]
// Front end: parses the BMP header, skips to the pixel data and classifies
// pixel bytes into tokens. Depends on bmpd_pkg.
`default_nettype none

module bmpd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     data_byte,
  input  wire logic           start_of_file,
  input  wire logic           q_full,
  output logic                push,
  output bmpd_pkg::token_t    tok
);

  // Parser phases.
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_PIXEL  = 2'd2;
  localparam logic [1:0] PH_HALT   = 2'd3;

  // Header byte positions that complete a field.
  localparam logic [31:0] POS_SIG   = 32'd1;
  localparam logic [31:0] POS_OFF   = 32'd13;
  localparam logic [31:0] POS_WID   = 32'd21;
  localparam logic [31:0] POS_HGT   = 32'd25;
  localparam logic [31:0] POS_PLN   = 32'd27;
  localparam logic [31:0] POS_DEP   = 32'd29;
  localparam logic [31:0] POS_CMP   = 32'd33;
  localparam logic [31:0] MIN_OFF   = 32'd34;
  localparam logic [15:0] SIG_BM    = 16'h4D42;
  localparam logic [15:0] PLANES_OK = 16'd1;
  localparam logic [15:0] DEPTH_OK  = 16'd24;

  localparam int DW = bmpd_pkg::DIM_W;
  localparam int CW = bmpd_pkg::COORD_W;

  logic [1:0]    phase, phase_next, c_phase;
  logic [31:0]   bpos, bpos_next, c_bpos;
  logic [31:0]   shift, shift_next, c_shift;
  logic [DW-1:0] width, width_next;
  logic [DW-1:0] height, height_next;
  logic [31:0]   offset, offset_next;
  logic [1:0]    bip, bip_next, c_bip;
  logic [CW-1:0] col, col_next, c_col;
  logic [DW-1:0] rows, rows_next, c_rows;
  logic [1:0]    pad, pad_next, c_pad;

  logic                          accept;
  logic                          tok_push;
  logic                          do_pixel;
  logic [bmpd_pkg::STATUS_W-1:0] err;
  logic [DW-1:0]                 col_inc;
  logic                          dim_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && tok_push;

  // Apply a restart, then process the byte.
  always_comb begin
    c_phase = start_of_file ? PH_HEADER : phase;
    c_bpos  = start_of_file ? '0 : bpos;
    c_shift = start_of_file ? '0 : shift;
    c_bip   = start_of_file ? '0 : bip;
    c_col   = start_of_file ? '0 : col;
    c_rows  = start_of_file ? '0 : rows;
    c_pad   = start_of_file ? '0 : pad;

    phase_next  = c_phase;
    bpos_next   = c_bpos;
    shift_next  = c_shift;
    width_next  = width;
    height_next = height;
    offset_next = offset;
    bip_next    = c_bip;
    col_next    = c_col;
    rows_next   = c_rows;
    pad_next    = c_pad;
    tok         = '0;
    tok_push    = 1'b0;
    do_pixel    = 1'b0;
    err         = bmpd_pkg::ST_PIXEL;
    col_inc     = {1'b0, c_col} + DW'(1);
    dim_ok      = 1'b0;

    case (c_phase)
      PH_HEADER: begin
        shift_next = {data_byte, c_shift[31:8]};
        dim_ok = (shift_next != 32'd0) && (shift_next <= 32'(bmpd_pkg::MAX_DIM));
        case (c_bpos)
          POS_SIG: begin
            if (shift_next[31:16] != SIG_BM) err = bmpd_pkg::ST_BAD_SIG;
          end
          POS_OFF: begin
            offset_next = shift_next;
            if (shift_next < MIN_OFF) err = bmpd_pkg::ST_BAD_SIZE;
          end
          POS_WID: begin
            if (!dim_ok) err = bmpd_pkg::ST_BAD_SIZE;
            else width_next = shift_next[DW-1:0];
          end
          POS_HGT: begin
            if (!dim_ok) err = bmpd_pkg::ST_BAD_SIZE;
            else height_next = shift_next[DW-1:0];
          end
          POS_PLN: begin
            if (shift_next[31:16] != PLANES_OK) err = bmpd_pkg::ST_BAD_PLANES;
          end
          POS_DEP: begin
            if (shift_next[31:16] != DEPTH_OK) err = bmpd_pkg::ST_BAD_DEPTH;
          end
          POS_CMP: begin
            if (shift_next != 32'd0) begin
              err = bmpd_pkg::ST_BAD_COMP;
            end else begin
              rows_next  = height;
              col_next   = '0;
              bip_next   = '0;
              pad_next   = '0;
              phase_next = PH_SKIP;
            end
          end
          default: ;
        endcase
        // Report the first failing check and halt.
        if (err != bmpd_pkg::ST_PIXEL) begin
          tok_push    = 1'b1;
          tok.kind    = bmpd_pkg::TK_ERROR;
          tok.status  = err;
          phase_next  = PH_HALT;
        end else begin
          bpos_next = c_bpos + 32'd1;
        end
      end
      PH_SKIP: begin
        if (c_bpos < offset) begin
          bpos_next = c_bpos + 32'd1;
        end else begin
          phase_next = PH_PIXEL;
          do_pixel   = 1'b1;
        end
      end
      PH_PIXEL: begin
        do_pixel = 1'b1;
      end
      default: ;
    endcase

    // Drop padding, then sort pixel bytes by component.
    if (do_pixel) begin
      tok.data = data_byte;
      if (c_pad != 2'd0) begin
        pad_next = c_pad - 2'd1;
      end else if (c_bip == 2'd0) begin
        tok_push = 1'b1;
        tok.kind = bmpd_pkg::TK_BLUE;
        bip_next = 2'd1;
      end else if (c_bip == 2'd1) begin
        tok_push = 1'b1;
        tok.kind = bmpd_pkg::TK_GREEN;
        bip_next = 2'd2;
      end else begin
        tok_push   = 1'b1;
        tok.kind   = bmpd_pkg::TK_RED;
        tok.status = bmpd_pkg::ST_PIXEL;
        tok.row    = CW'(c_rows - DW'(1));
        tok.column = c_col;
        tok.last   = (c_rows == DW'(1)) && (col_inc == width);
        bip_next   = 2'd0;
        if (col_inc >= width) begin
          col_next  = '0;
          rows_next = c_rows - DW'(1);
          if (c_rows == DW'(1)) phase_next = PH_HALT;
          else pad_next = width[1:0];
        end else begin
          col_next = col_inc[CW-1:0];
        end
      end
    end
  end

  // Hold parser state; advance on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      bpos  <= '0;
      shift <= '0;
      bip   <= '0;
      col   <= '0;
      rows  <= '0;
      pad   <= '0;
    end else if (accept) begin
      phase <= phase_next;
      bpos  <= bpos_next;
      shift <= shift_next;
      bip   <= bip_next;
      col   <= col_next;
      rows  <= rows_next;
      pad   <= pad_next;
    end
  end

  // Header fields carry no reset; each is written before use.
  always_ff @(posedge clk) begin
    if (accept) begin
      width  <= width_next;
      height <= height_next;
      offset <= offset_next;
    end
  end

endmodule

`default_nettype wire

[src/bmpd_queue.sv]
// Short token queue between the front and back of the decoder.
// Depends on bmpd_pkg for the token type and depth.
`default_nettype none

module bmpd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire bmpd_pkg::token_t push_tok,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output bmpd_pkg::token_t      q_tok
);

  localparam int PW = bmpd_pkg::QPTR_W;
  localparam int NW = bmpd_pkg::QCOUNT_W;

  bmpd_pkg::token_t mem [bmpd_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == NW'(bmpd_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_tok   = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Store pushed tokens.
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_tok;
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(bmpd_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(bmpd_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) count <= count + NW'(1);
      else if (do_pop && !do_push) count <= count - NW'(1);
    end
  end

endmodule

`default_nettype wire

[src/bmpd_back.sv]
// Back end: collects blue and green bytes and assembles result words
// in an output register. Depends on bmpd_pkg.
`default_nettype none

module bmpd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire bmpd_pkg::token_t q_tok,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [bmpd_pkg::STATUS_W-1:0] status,
  output logic [bmpd_pkg::COORD_W-1:0]  row,
  output logic [bmpd_pkg::COORD_W-1:0]  column,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  output logic                          last_pixel
);

  logic [7:0] held_blue, held_green;
  logic       is_comp;
  logic       slot_free;
  logic       load;

  // Blue and green words never need the output slot.
  always_comb begin
    is_comp   = q_tok.kind inside {bmpd_pkg::TK_BLUE, bmpd_pkg::TK_GREEN};
    slot_free = !out_valid || out_ready;
    pop       = q_valid && (is_comp || slot_free);
    load      = q_valid && !is_comp && slot_free;
  end

  // Hold component bytes until the red byte arrives.
  always_ff @(posedge clk) begin
    if (pop && q_tok.kind == bmpd_pkg::TK_BLUE) held_blue <= q_tok.data;
    if (pop && q_tok.kind == bmpd_pkg::TK_GREEN) held_green <= q_tok.data;
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result word.
  always_ff @(posedge clk) begin
    if (load) begin
      status     <= q_tok.status;
      row        <= q_tok.row;
      column     <= q_tok.column;
      last_pixel <= q_tok.last;
      if (q_tok.kind == bmpd_pkg::TK_RED) begin
        red   <= q_tok.data;
        green <= held_green;
        blue  <= held_blue;
      end else begin
        red   <= '0;
        green <= '0;
        blue  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[src/bmp_rgb24_stream_decoder.sv]
// Top level of the 24-bit BMP stream decoder: front parser, token queue
// and output stage. Depends on bmpd_pkg, bmpd_front, bmpd_queue, bmpd_back.
//
//   Channel | Direction | Handshake            | Word
//   --------+-----------+----------------------+-----------------------------------
//   in      | input     | in_valid / in_ready  | data_byte, start_of_file
//   out     | output    | out_valid / out_ready| status, row, column, red, green,
//           |           |                      | blue, last_pixel
//
// One input word is taken every cycle while the four-entry token queue has room.
// A result word is registered in the token queue and then in the output register;
// while the output side is stalled, completed words wait in the queue.
// Reset clears the parser, queue and output valid; no clearing pass is needed.
// An output stall backs up the queue; in_ready drops only when the queue is full.
`default_nettype none

module bmp_rgb24_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       start_of_file,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      status,
  output logic [11:0]     row,
  output logic [11:0]     column,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic            last_pixel
);

  bmpd_pkg::token_t f_tok, q_tok;
  logic             f_push, q_full, q_valid, q_pop;

  bmpd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_of_file (start_of_file),
    .q_full        (q_full),
    .push          (f_push),
    .tok           (f_tok)
  );

  bmpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .push_tok (f_tok),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  bmpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_tok      (q_tok),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .row        (row),
    .column     (column),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .last_pixel (last_pixel)
  );

endmodule

`default_nettype wire

[test/tb_bmp_rgb24_stream_decoder.sv]
// Self-checking testbench for bmp_rgb24_stream_decoder: streams BMP files byte by byte
// and checks every pixel and error word against a built-in decoder model.
// Depends on bmpd_pkg and the decoder RTL only.
`default_nettype none

module tb_bmp_rgb24_stream_decoder;

  localparam logic [15:0] SIG_BM      = 16'h4D42;
  localparam logic [15:0] PLANES_ONE  = 16'd1;
  localparam logic [15:0] DEPTH_RGB24 = 16'd24;
  localparam logic [31:0] COMP_NONE   = 32'd0;
  localparam logic [31:0] MIN_OFFSET  = 32'd34;

  localparam int unsigned RANDOM_BYTES = 100;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned PRINT_CAP    = 40;

  typedef enum logic [1:0] {
    STAGE_HEADER,
    STAGE_SKIP,
    STAGE_PIXELS,
    STAGE_HALTED
  } decode_stage_t;

  typedef struct packed {
    logic [bmpd_pkg::STATUS_W-1:0] status;
    logic [bmpd_pkg::COORD_W-1:0]  row;
    logic [bmpd_pkg::COORD_W-1:0]  column;
    logic [7:0]                    red;
    logic [7:0]                    green;
    logic [7:0]                    blue;
    logic                          last;
  } pixel_word_t;

  // Decoder model plus the queue of pixel and error words still owed by the DUT.
  class bmp_pixel_board;
    decode_stage_t stage;
    logic [31:0]   byte_count;
    logic [31:0]   window;
    logic [31:0]   pixel_offset;
    int unsigned   img_width;
    int unsigned   img_height;
    int unsigned   rows_left;
    int unsigned   next_column;
    int unsigned   pad_left;
    int unsigned   byte_phase;
    logic [7:0]    held_blue;
    logic [7:0]    held_green;
    pixel_word_t   expected[$];
    int unsigned   mismatches;

    function new();
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      stage        = STAGE_HEADER;
      byte_count   = 0;
      window       = 0;
      pixel_offset = 0;
      img_width    = 0;
      img_height   = 0;
      rows_left    = 0;
      next_column  = 0;
      pad_left     = 0;
      byte_phase   = 0;
      held_blue    = 0;
      held_green   = 0;
    endfunction

    function void halt_with(logic [bmpd_pkg::STATUS_W-1:0] code);
      pixel_word_t px;
      px        = '0;
      px.status = code;
      expected.push_back(px);
      stage = STAGE_HALTED;
    endfunction

    function void take_pixel_byte(logic [7:0] b);
      pixel_word_t px;
      // drop row padding first
      if (pad_left != 0) begin
        pad_left--;
        return;
      end
      if (byte_phase == 0) begin
        held_blue  = b;
        byte_phase = 1;
        return;
      end
      if (byte_phase == 1) begin
        held_green = b;
        byte_phase = 2;
        return;
      end
      byte_phase = 0;
      px.status  = bmpd_pkg::ST_PIXEL;
      px.row     = 12'(rows_left - 1);
      px.column  = 12'(next_column);
      px.red     = b;
      px.green   = held_green;
      px.blue    = held_blue;
      px.last    = (rows_left == 1) && (next_column + 1 == img_width);
      expected.push_back(px);
      // advance to the next column, wrapping to the row above
      next_column++;
      if (next_column >= img_width) begin
        next_column = 0;
        rows_left--;
        if (rows_left == 0) stage = STAGE_HALTED;
        else pad_left = img_width & 3;
      end
    endfunction

    // Note one accepted input word and queue whatever it produces.
    function void note_byte(logic [7:0] b, logic sof);
      if (sof) restart();
      case (stage)
        STAGE_HEADER: begin
          window = {b, window[31:8]};
          case (byte_count)
            1: if (window[31:16] != SIG_BM) halt_with(bmpd_pkg::ST_BAD_SIG);
            13: begin
              pixel_offset = window;
              if (window < MIN_OFFSET) halt_with(bmpd_pkg::ST_BAD_SIZE);
            end
            21: begin
              if (window - 32'd1 >= bmpd_pkg::MAX_DIM) halt_with(bmpd_pkg::ST_BAD_SIZE);
              else img_width = window;
            end
            25: begin
              if (window - 32'd1 >= bmpd_pkg::MAX_DIM) halt_with(bmpd_pkg::ST_BAD_SIZE);
              else img_height = window;
            end
            27: if (window[31:16] != PLANES_ONE) halt_with(bmpd_pkg::ST_BAD_PLANES);
            29: if (window[31:16] != DEPTH_RGB24) halt_with(bmpd_pkg::ST_BAD_DEPTH);
            33: begin
              if (window != COMP_NONE) begin
                halt_with(bmpd_pkg::ST_BAD_COMP);
              end else begin
                rows_left   = img_height;
                next_column = 0;
                byte_phase  = 0;
                pad_left    = 0;
                stage       = STAGE_SKIP;
              end
            end
            default: ;
          endcase
          byte_count++;
        end
        STAGE_SKIP: begin
          if (byte_count < pixel_offset) begin
            byte_count++;
          end else begin
            stage = STAGE_PIXELS;
            take_pixel_byte(b);
          end
        end
        STAGE_PIXELS: take_pixel_byte(b);
        default: ;
      endcase
    endfunction

    function string describe(pixel_word_t p);
      return $sformatf("st=%0d row=%0d col=%0d rgb=%02h%02h%02h last=%0b",
                       p.status, p.row, p.column, p.red, p.green, p.blue, p.last);
    endfunction

    task report_mismatch(string msg);
      // keep the log short when everything goes wrong
      if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(pixel_word_t got);
      pixel_word_t want;
      string       bad;
      if (expected.size() == 0) begin
        report_mismatch({"unexpected word ", describe(got)});
        return;
      end
      want = expected.pop_front();
      bad  = "";
      if (got.status != want.status) bad = {bad, " status"};
      if (got.row    != want.row)    bad = {bad, " row"};
      if (got.column != want.column) bad = {bad, " column"};
      if (got.red    != want.red)    bad = {bad, " red"};
      if (got.green  != want.green)  bad = {bad, " green"};
      if (got.blue   != want.blue)   bad = {bad, " blue"};
      if (got.last   != want.last)   bad = {bad, " last_pixel"};
      if (bad != "")
        report_mismatch({"wrong", bad, ": got ", describe(got), " want ", describe(want)});
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        start_of_file;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [11:0] row;
  logic [11:0] column;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_pixel;

  bmp_pixel_board board;
  logic [7:0]     file_image[$];
  int unsigned    burst_left;
  logic           hold_request;

  bmp_rgb24_stream_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .start_of_file(start_of_file),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .row          (row),
    .column       (column),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .last_pixel   (last_pixel)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop in case the DUT hangs.
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Check every accepted output word.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(pixel_word_t'({status, row, column, red, green, blue, last_pixel}));
  end

  // Stall the output on a pattern that changes every stretch; honor long hold requests.
  initial begin : receiver
    int unsigned mode;
    int unsigned stretch;
    int unsigned k;
    out_ready = 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(16, 160);
      for (k = 0; k < stretch; k++) begin
        @(posedge clk);
        if (hold_request) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_request = 1'b0;
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((k % 8) < 5);
        endcase
      end
    end
  end

  function void put_le(logic [31:0] v, int unsigned n);
    for (int i = 0; i < n; i++) file_image.push_back(v[8*i +: 8]);
  endfunction

  function logic [7:0] pixel_value();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function logic [31:0] bad_dim();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return bmpd_pkg::MAX_DIM + 1;
      2:       return $urandom_range(32'h7FFF_FFFF, bmpd_pkg::MAX_DIM + 1);
      default: return $urandom | 32'h8000_0000;
    endcase
  endfunction

  // Assemble a file image; pixel data follows only when every header field is legal.
  function void build_file(logic [15:0] sig, logic [31:0] off, logic [31:0] w,
                           logic [31:0] h, logic [15:0] planes, logic [15:0] depth,
                           logic [31:0] comp);
    file_image.delete();
    put_le(sig, 2);
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le(off, 4);
    put_le($urandom, 4);
    put_le(w, 4);
    put_le(h, 4);
    put_le(planes, 2);
    put_le(depth, 2);
    put_le(comp, 4);
    if (sig == SIG_BM && off >= MIN_OFFSET && w - 32'd1 < bmpd_pkg::MAX_DIM
        && h - 32'd1 < bmpd_pkg::MAX_DIM
        && planes == PLANES_ONE && depth == DEPTH_RGB24 && comp == COMP_NONE) begin
      while (file_image.size() < off) file_image.push_back(8'($urandom));
      for (int r = 0; r < h; r++) begin
        for (int c = 0; c < 3 * w; c++) file_image.push_back(pixel_value());
        if (r + 1 < h) repeat (w & 3) file_image.push_back(8'($urandom));
      end
    end
  endfunction

  // Offer one input word in bursts with random gaps, and hold it until taken.
  task send_byte(input logic [7:0] b, input logic sof);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid      <= 1'b1;
    data_byte     <= b;
    start_of_file <= sof;
    do @(posedge clk); while (!in_ready);
    board.note_byte(b, sof);
  endtask

  // Stream the first count bytes of the image; scatter sets restart flags at random.
  task send_file(input int unsigned count, input bit flag_first, input bit scatter);
    for (int k = 0; k < count && k < file_image.size(); k++)
      send_byte(file_image[k], (flag_first && k == 0) || (scatter && $urandom_range(0, 15) == 0));
  endtask

  task send_junk(input int unsigned n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  task run_file(input logic [15:0] sig, input logic [31:0] off, input logic [31:0] w,
                input logic [31:0] h, input logic [15:0] planes, input logic [15:0] depth,
                input logic [31:0] comp);
    build_file(sig, off, w, h, planes, depth, comp);
    send_file(file_image.size(), 1'b1, 1'b0);
  endtask

  // Send only the first count bytes of a file, e.g. a header up to its failing field.
  task run_cut(input int unsigned count, input logic [15:0] sig, input logic [31:0] off,
               input logic [31:0] w, input logic [31:0] h, input logic [15:0] planes,
               input logic [15:0] depth, input logic [31:0] comp);
    build_file(sig, off, w, h, planes, depth, comp);
    send_file(count, 1'b1, 1'b0);
  endtask

  // Stop offering words until every owed word has come out.
  task wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.expected.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned kind;
    int unsigned cut;
    int unsigned random_bytes;
    logic [15:0] sig;
    logic [15:0] planes;
    logic [15:0] depth;
    logic [31:0] off;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] comp;

    board         = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    data_byte     = 8'd0;
    start_of_file = 1'b0;
    hold_request  = 1'b0;
    burst_left    = 0;
    random_bytes  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // smallest image straight after reset with no start flag, then bytes while halted
    build_file(SIG_BM, MIN_OFFSET, 1, 1, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    send_file(file_image.size(), 1'b0, 1'b0);
    send_junk(3);
    // aligned rows with two skipped bytes, then three bytes of padding per row
    run_file(SIG_BM, MIN_OFFSET + 2, 4, 2, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    run_file(SIG_BM, MIN_OFFSET, 3, 3, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    // each header check failing on its own, with a couple of bytes past the failure
    run_cut(4, 16'h4E42, MIN_OFFSET, 2, 2, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    run_cut(16, SIG_BM, MIN_OFFSET - 1, 2, 2, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    run_cut(16, SIG_BM, 0, 2, 2, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    run_cut(24, SIG_BM, MIN_OFFSET, 0, 2, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    run_cut(24, SIG_BM, MIN_OFFSET, 32'hFFFF_FFFF, 2, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    run_cut(24, SIG_BM, MIN_OFFSET, bmpd_pkg::MAX_DIM + 1, 2, PLANES_ONE, DEPTH_RGB24,
            COMP_NONE);
    run_cut(28, SIG_BM, MIN_OFFSET, 2, 0, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    run_cut(28, SIG_BM, MIN_OFFSET, 2, 32'h8000_0000, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    run_cut(30, SIG_BM, MIN_OFFSET, 2, 2, 16'h0101, DEPTH_RGB24, COMP_NONE);
    run_cut(32, SIG_BM, MIN_OFFSET, 2, 2, PLANES_ONE, 16'd32, COMP_NONE);
    run_file(SIG_BM, MIN_OFFSET, 2, 2, PLANES_ONE, DEPTH_RGB24, 32'h0100_0000);
    // the earliest failing field is the one reported
    run_cut(16, SIG_BM, 32'd10, 0, 2, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    run_cut(30, SIG_BM, MIN_OFFSET, 2, 2, 16'd0, 16'd8, 32'd1);
    // restart inside the header, then inside pixel data, then a short file left waiting
    build_file(SIG_BM, MIN_OFFSET, 5, 3, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    send_file(20, 1'b1, 1'b0);
    send_file(file_image.size() - 7, 1'b1, 1'b0);
    run_file(SIG_BM, MIN_OFFSET + 1, 2, 1, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    build_file(SIG_BM, MIN_OFFSET, 3, 2, PLANES_ONE, DEPTH_RGB24, COMP_NONE);
    send_file(40, 1'b1, 1'b0);
    wait_drained();

    // start of the largest width under a long output hold, then of the largest height
    hold_request = 1'b1;
    run_cut(MIN_OFFSET + 18, SIG_BM, MIN_OFFSET, bmpd_pkg::MAX_DIM, 1, PLANES_ONE,
            DEPTH_RGB24, COMP_NONE);
    run_cut(MIN_OFFSET + 24, SIG_BM, MIN_OFFSET, 1, bmpd_pkg::MAX_DIM, PLANES_ONE,
            DEPTH_RGB24, COMP_NONE);
    wait_drained();

    // random files: mostly well formed, some with one bad field, some plain noise
    while (random_bytes < RANDOM_BYTES) begin
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 14) == 0) hold_request = 1'b1;
      if (kind <= 6) begin
        build_file(SIG_BM, MIN_OFFSET + $urandom_range(0, 6), $urandom_range(1, 8),
                   $urandom_range(1, 3), PLANES_ONE, DEPTH_RGB24, COMP_NONE);
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, file_image.size())
                                          : file_image.size();
        send_file(cut, 1'b1, 1'b0);
      end else if (kind <= 8) begin
        sig    = SIG_BM;
        off    = MIN_OFFSET + $urandom_range(0, 4);
        w      = $urandom_range(1, 6);
        h      = $urandom_range(1, 3);
        planes = PLANES_ONE;
        depth  = DEPTH_RGB24;
        comp   = COMP_NONE;
        case ($urandom_range(0, 6))
          0:       sig    = SIG_BM ^ 16'($urandom_range(16'hFFFF, 1));
          1:       off    = $urandom_range(0, MIN_OFFSET - 1);
          2:       w      = bad_dim();
          3:       h      = bad_dim();
          4:       planes = PLANES_ONE ^ 16'($urandom_range(16'hFFFF, 1));
          5:       depth  = DEPTH_RGB24 ^ 16'($urandom_range(16'hFFFF, 1));
          default: comp   = $urandom | 32'h0000_0100;
        endcase
        build_file(sig, off, w, h, planes, depth, comp);
        cut = file_image.size();
        send_file(cut, 1'b1, 1'b0);
      end else begin
        file_image.delete();
        repeat ($urandom_range(1, 40)) file_image.push_back(8'($urandom));
        cut = file_image.size();
        send_file(cut, 1'b1, 1'b1);
      end
      random_bytes += cut;
      send_junk($urandom_range(0, 2));
      if ($urandom_range(0, 11) == 0) wait_drained();
    end

    // let the last words out, then watch for strays
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.expected.size() != 0)
      board.report_mismatch($sformatf("%0d words never arrived", board.expected.size()));
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
